// ===== sv/ckib_pkg.sv =====
// Shared types and constants for the canonical k-mer index builder.
`default_nettype none

package ckib_pkg;

    localparam int unsigned CODE_W      = 16;
    localparam int unsigned ID_W        = 16;
    localparam int unsigned CFG_W       = 4;
    localparam int unsigned TABLE_DEPTH = 65536;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef struct packed {
        logic [CODE_W-1:0] fwd;
        logic [CODE_W-1:0] rev;
        logic              fresh;
        logic              last;
        logic              overrun;
    } t_kmer_info;

endpackage

`default_nettype wire

// ===== sv/ckib_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ckib_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 65536
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/ckib_kmer.sv =====
// K-mer code unit: reverse complement, last code and ordering for one position.
`default_nettype none

module ckib_kmer #(
    parameter int unsigned MAX_KMER_LEN = 8
) (
    input  wire  [2*MAX_KMER_LEN-1:0]  i_pos,
    input  wire  [ckib_pkg::CFG_W-1:0] i_kmer_len,
    output ckib_pkg::t_kmer_info       o_info
);

    localparam int unsigned CW   = 2 * MAX_KMER_LEN;
    localparam int unsigned KW   = $clog2(MAX_KMER_LEN + 1);
    localparam int unsigned CMPW = (KW > ckib_pkg::CFG_W) ? KW : ckib_pkg::CFG_W;
    localparam int unsigned EW   = (CW > ckib_pkg::CODE_W) ? CW : ckib_pkg::CODE_W;

    logic [CMPW-1:0] len_ext;
    logic [KW-1:0]   k_eff;
    logic [KW-1:0]   shift;
    logic [CW-1:0]   full_rev;
    logic [CW-1:0]   rev;
    logic [CW-1:0]   last_code;
    logic [EW-1:0]   fwd_ext;
    logic [EW-1:0]   rev_ext;

    // clamp length into 1..MAX_KMER_LEN
    always_comb begin
        len_ext = CMPW'(i_kmer_len);
        priority if (len_ext == '0) begin
            k_eff = KW'(1);
        end else if (len_ext > CMPW'(MAX_KMER_LEN)) begin
            k_eff = KW'(MAX_KMER_LEN);
        end else begin
            k_eff = KW'(len_ext);
        end
        shift = KW'(MAX_KMER_LEN) - k_eff;
    end

    // complement and mirror all digits, then drop the unused ones
    always_comb begin
        for (int j = 0; j < MAX_KMER_LEN; j++) begin
            full_rev[2*(MAX_KMER_LEN-1-j) +: 2] = ~i_pos[2*j +: 2];
        end
    end

    assign rev       = full_rev >> {shift, 1'b0};
    assign last_code = {CW{1'b1}} >> {shift, 1'b0};
    assign fwd_ext   = EW'(i_pos);
    assign rev_ext   = EW'(rev);

    assign o_info.fwd     = fwd_ext[ckib_pkg::CODE_W-1:0];
    assign o_info.rev     = rev_ext[ckib_pkg::CODE_W-1:0];
    assign o_info.fresh   = (i_pos <= rev);
    assign o_info.last    = (i_pos == last_code);
    assign o_info.overrun = (i_pos > last_code);

endmodule

`default_nettype wire

// ===== sv/canonical_kmer_index_builder.sv =====
// Canonical k-mer index builder top level: enumeration control and id table.
//
//  channel   | direction | handshake                         | contents
//  s_axis    | in        | i_s_axis_tvalid / o_s_axis_tready | tdata[0] start_over
//  m_axis    | out       | o_m_axis_tvalid / i_m_axis_tready | tdata ids, tuser flags, tlast
//  cfg       | in        | i_cfg_valid / o_cfg_ready         | kmer_length
//
//  A k-mer that takes a new id, and a finished word, is handled in ST_IDLE alone.
//  A k-mer that reuses an id passes ST_IDLE, which reads the id table at the
//  reverse code, then ST_LOOKUP, which writes that id back at the k-mer's own code.
//  The next word is taken in ST_IDLE once the output register is free or being drained.
//  Reset is synchronous; the id table needs no clearing.
`default_nettype none

module canonical_kmer_index_builder #(
    parameter int unsigned MAX_KMER_LEN = 8
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire  [7:0]                i_s_axis_tdata,   // [0] start_over, [7:1] zero
    output logic                      o_m_axis_tvalid,
    input  wire                       i_m_axis_tready,
    output logic [47:0]               o_m_axis_tdata,   // [15:0] forward_code,
                                                        // [31:16] reverse_code,
                                                        // [47:32] canonical_id
    output logic [1:0]                o_m_axis_tuser,   // [0] valid_res, [1] new_id
    output logic                      o_m_axis_tlast,   // last
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire  [ckib_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int unsigned CW  = 2 * MAX_KMER_LEN;
    localparam int unsigned AW  = $clog2(ckib_pkg::TABLE_DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    t_state                     r_state, n_state;
    logic [ckib_pkg::CFG_W-1:0] r_kmer_len, n_kmer_len;
    logic [CW-1:0]              r_pos, n_pos;
    logic                       r_fin, n_fin;
    logic [ckib_pkg::ID_W-1:0]  r_cnt, n_cnt;
    logic                       r_m_valid, n_m_valid;
    logic [ckib_pkg::CODE_W-1:0] r_m_fwd, n_m_fwd;
    logic [ckib_pkg::CODE_W-1:0] r_m_rev, n_m_rev;
    logic [ckib_pkg::ID_W-1:0]  r_m_id, n_m_id;
    logic                       r_m_res, n_m_res;
    logic                       r_m_new, n_m_new;
    logic                       r_m_last, n_m_last;

    logic                       start;
    logic                       fire;
    logic [CW-1:0]              pos_eff;
    logic                       fin_eff;
    logic [ckib_pkg::ID_W-1:0]  cnt_eff;
    logic                       fin_now;
    ckib_pkg::t_kmer_info       info;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [ckib_pkg::ID_W-1:0]  ram_wdata;
    logic                       ram_re;
    logic [ckib_pkg::ID_W-1:0]  ram_rdata;

    assign start   = i_s_axis_tdata[0];
    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_m_valid || i_m_axis_tready);
    assign fire    = i_s_axis_tvalid && o_s_axis_tready;
    assign pos_eff = start ? '0 : r_pos;
    assign fin_eff = start ? 1'b0 : r_fin;
    assign cnt_eff = start ? '0 : r_cnt;
    assign fin_now = fin_eff || info.overrun;

    ckib_kmer #(
        .MAX_KMER_LEN (MAX_KMER_LEN)
    ) u_kmer (
        .i_pos      (pos_eff),
        .i_kmer_len (r_kmer_len),
        .o_info     (info)
    );

    ckib_ram #(
        .WIDTH (ckib_pkg::ID_W),
        .DEPTH (ckib_pkg::TABLE_DEPTH)
    ) u_id_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (AW'(info.rev)),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        ram_re    = fire && !fin_now && !info.fresh;
        ram_we    = 1'b0;
        ram_waddr = AW'(info.fwd);
        ram_wdata = cnt_eff;

        n_state    = r_state;
        n_kmer_len = (i_cfg_valid) ? i_cfg_data : r_kmer_len;
        n_pos      = r_pos;
        n_fin      = r_fin;
        n_cnt      = r_cnt;
        n_m_valid  = r_m_valid && !i_m_axis_tready;
        n_m_fwd    = r_m_fwd;
        n_m_rev    = r_m_rev;
        n_m_id     = r_m_id;
        n_m_res    = r_m_res;
        n_m_new    = r_m_new;
        n_m_last   = r_m_last;

        unique case (r_state)
            ST_IDLE: begin
                if (fire) begin
                    n_pos = pos_eff;
                    n_cnt = cnt_eff;
                    n_fin = fin_now;
                    if (fin_now) begin
                        n_m_valid = 1'b1;
                        n_m_res   = 1'b0;
                        n_m_fwd   = '0;
                        n_m_rev   = '0;
                        n_m_id    = '0;
                        n_m_new   = 1'b0;
                        n_m_last  = 1'b0;
                    end else begin
                        n_m_res  = 1'b1;
                        n_m_fwd  = info.fwd;
                        n_m_rev  = info.rev;
                        n_m_new  = info.fresh;
                        n_m_last = info.last;
                        if (info.last) begin
                            n_fin = 1'b1;
                        end else begin
                            n_pos = pos_eff + CW'(1);
                        end
                        if (info.fresh) begin
                            ram_we    = 1'b1;
                            n_m_id    = cnt_eff;
                            n_cnt     = cnt_eff + ckib_pkg::ID_W'(1);
                            n_m_valid = 1'b1;
                        end else begin
                            n_m_valid = 1'b0;
                            n_state   = ST_LOOKUP;
                        end
                    end
                end
            end
            ST_LOOKUP: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_m_fwd);
                ram_wdata = ram_rdata;
                n_m_id    = ram_rdata;
                n_m_valid = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_kmer_len <= ckib_pkg::CFG_RESET;
            r_pos      <= '0;
            r_fin      <= 1'b0;
            r_cnt      <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_kmer_len <= n_kmer_len;
            r_pos      <= n_pos;
            r_fin      <= n_fin;
            r_cnt      <= n_cnt;
            r_m_valid  <= n_m_valid;
        end
        r_m_fwd  <= n_m_fwd;
        r_m_rev  <= n_m_rev;
        r_m_id   <= n_m_id;
        r_m_res  <= n_m_res;
        r_m_new  <= n_m_new;
        r_m_last <= n_m_last;
    end

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {r_m_id, r_m_rev, r_m_fwd};
    assign o_m_axis_tuser  = {r_m_new, r_m_res};
    assign o_m_axis_tlast  = r_m_last;

endmodule

`default_nettype wire
